// ===== rtl/core/rlptd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlptd_pkg
// Shared types and constants of the rate-limited priority task dispatcher.
// ----------------------------------------------------------------------------
package rlptd_pkg;

    localparam int TIME_BITS   = 32;
    localparam int NOW_W       = 32;
    localparam int SWR_W       = 16;
    localparam int REG_W       = 16;
    localparam int NUM_REGS    = 7;
    localparam int NUM_TIMERS  = 6;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int TASK_W      = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [REG_W-1:0]     reg_val_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POLL_PERIOD = 3'd0,
        REG_FREQ_PERIOD = 3'd1,
        REG_MEAS_PERIOD = 3'd2,
        REG_TUNE_PERIOD = 3'd3,
        REG_BAR_PERIOD  = 3'd4,
        REG_SAVE_PERIOD = 3'd5,
        REG_SWR_THRESH  = 3'd6
    } reg_idx_t;

    localparam int T_POLL = 0;
    localparam int T_FREQ = 1;
    localparam int T_MEAS = 2;
    localparam int T_TUNE = 3;
    localparam int T_BAR  = 4;
    localparam int T_SAVE = 5;

    typedef enum logic [TASK_W-1:0] {
        TASK_NONE     = 3'd0,
        TASK_POLL     = 3'd1,
        TASK_FREQ     = 3'd2,
        TASK_MEAS     = 3'd3,
        TASK_TUNE_REQ = 3'd4,
        TASK_BAR      = 3'd5,
        TASK_SAVE     = 3'd6
    } task_code_t;

    typedef struct packed {
        reg_val_t [NUM_TIMERS-1:0] period;
        reg_val_t                  swr_threshold;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             rf_present;
        logic             auto_mode;
        logic [SWR_W-1:0] swr_reading;
    } call_t;

    typedef struct packed {
        logic       valid;
        task_code_t task_chosen;
    } result_t;

endpackage

// ===== rtl/core/rate_limited_priority_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// rate_limited_priority_task_dispatcher
// Picks one idle-loop task per call by cooldown timers and fixed priority.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transfer per idle-loop call. tdata carries the
//   millisecond time and SWR code, tuser the RF-present and auto-mode flags.
//   Master stream: one transfer per call with the chosen task code
//   (0 none, 1 poll, 2 frequency, 3 measure, 4 tune request, 5 bargraph,
//   6 save).
//   APB port: periods and SWR threshold at byte offsets 0x00..0x18, to be
//   written only while no call is in flight (the block does not enforce it).
//   Path: the input register feeds the pick logic straight into the result
//   register, which drives the master stream.
//   Throughput: one call per cycle unless stalled; cooldown compares, priority
//   pick and timestamp update all finish in the single input-register stage.
//   Reset: registers return to default periods and a zero SWR threshold, all
//   timestamps clear to zero and the tune request is armed.
//   Stall: when m_tready is low the result holds, the input register fills
//   and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module rate_limited_priority_task_dispatcher
    import rlptd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms, [47:32] swr_reading
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [0] rf_present, [1] auto_mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] task_chosen, [7:3] zero
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    call_t   in_call;
    result_t res;
    logic    res_ready;

    assign in_call.now_ms      = s_tdata[NOW_W-1:0];
    assign in_call.swr_reading = s_tdata[NOW_W+SWR_W-1:NOW_W];
    assign in_call.rf_present  = s_tuser[0];
    assign in_call.auto_mode   = s_tuser[1];

    rlptd_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlptd_sched u_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_call   (in_call),
        .res_ready (res_ready),
        .res       (res)
    );

    rlptd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/core/rlptd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rlptd_cfg_regs
// APB register file holding the task periods and the SWR threshold.
// ----------------------------------------------------------------------------
module rlptd_cfg_regs
    import rlptd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    reg_val_t regs_reg [NUM_REGS];
    reg_val_t regs_next[NUM_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            regs_next[i] = regs_reg[i];
        end
        if (wr_en && (idx < REG_IDX_W'(NUM_REGS))) begin
            regs_next[idx] = pwdata[REG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_POLL_PERIOD] <= reg_val_t'(10);
            regs_reg[REG_FREQ_PERIOD] <= reg_val_t'(1000);
            regs_reg[REG_MEAS_PERIOD] <= reg_val_t'(20);
            regs_reg[REG_TUNE_PERIOD] <= reg_val_t'(200);
            regs_reg[REG_BAR_PERIOD]  <= reg_val_t'(33);
            regs_reg[REG_SAVE_PERIOD] <= reg_val_t'(200);
            regs_reg[REG_SWR_THRESH]  <= reg_val_t'(0);
        end else begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= regs_next[i];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx < REG_IDX_W'(NUM_REGS)) begin
            prdata = APB_DATA_W'(regs_reg[idx]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            cfg.period[i] = regs_reg[i];
        end
        cfg.swr_threshold = regs_reg[REG_SWR_THRESH];
    end

endmodule

// ===== rtl/core/rlptd_sched.sv =====
// ----------------------------------------------------------------------------
// rlptd_sched
// Input register, cooldown checks, priority pick and dispatch timestamps.
// ----------------------------------------------------------------------------
module rlptd_sched
    import rlptd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  call_t   in_call,
    input  logic    res_ready,
    output result_t res
);

    logic       call_valid_reg;
    call_t      call_reg;
    time_t      last_reg [NUM_TIMERS];
    time_t      last_next[NUM_TIMERS];
    logic       armed_reg;
    logic       armed_next;
    logic       advance;
    time_t      now;
    logic [NUM_TIMERS-1:0] cool;
    task_code_t task_sel;

    assign advance  = call_valid_reg && res_ready;
    assign in_ready = !call_valid_reg || res_ready;
    assign now      = time_t'(call_reg.now_ms);

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            cool[i] = time_t'(now - last_reg[i]) >= time_t'(cfg.period[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            last_next[i] = last_reg[i];
        end
        armed_next = armed_reg;
        task_sel   = TASK_NONE;
        if (cool[T_POLL]) begin
            last_next[T_POLL] = now;
            task_sel          = TASK_POLL;
        end else begin
            if (call_reg.rf_present) begin
                priority if (cool[T_FREQ]) begin
                    last_next[T_FREQ] = now;
                    task_sel          = TASK_FREQ;
                end else if (cool[T_MEAS]) begin
                    last_next[T_MEAS] = now;
                    task_sel          = TASK_MEAS;
                end else if (cool[T_TUNE]) begin
                    last_next[T_TUNE] = now;
                    if (call_reg.auto_mode && armed_reg &&
                        (call_reg.swr_reading > cfg.swr_threshold)) begin
                        armed_next = 1'b0;
                        task_sel   = TASK_TUNE_REQ;
                    end
                end else begin
                    task_sel = TASK_NONE;
                end
            end else begin
                armed_next = 1'b1;
            end
            if (task_sel == TASK_NONE) begin
                if (cool[T_BAR]) begin
                    last_next[T_BAR] = now;
                    task_sel         = TASK_BAR;
                end else if (cool[T_SAVE]) begin
                    last_next[T_SAVE] = now;
                    task_sel          = TASK_SAVE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            call_valid_reg <= 1'b0;
            armed_reg      <= 1'b1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                last_reg[i] <= '0;
            end
        end else begin
            if (in_ready) begin
                call_valid_reg <= in_valid;
            end
            if (advance) begin
                armed_reg <= armed_next;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    last_reg[i] <= last_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            call_reg <= in_call;
        end
    end

    assign res.valid       = call_valid_reg;
    assign res.task_chosen = task_sel;

endmodule

// ===== rtl/core/rlptd_out_reg.sv =====
// ----------------------------------------------------------------------------
// rlptd_out_reg
// Result register driving the master stream.
// ----------------------------------------------------------------------------
module rlptd_out_reg
    import rlptd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  result_t              res,
    output logic                 res_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic       valid_reg;
    task_code_t task_reg;

    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            task_reg <= res.task_chosen;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(task_reg);

endmodule

// ===== bench/rate_limited_priority_task_dispatcher_tb.sv =====
// ----------------------------------------------------------------------------
// rate_limited_priority_task_dispatcher_tb
// Self-checking bench for the idle-loop task dispatcher. A short table of
// calls after reset exercises each task, the tune fire and re-arm, and the
// time wrap. Random phases follow, each with its own period and threshold
// setting written over APB. Most calls step time forward in small increments;
// the rest jump to random times. Every accepted call is run through a local
// copy of the cooldown and priority logic, and every result transfer is
// compared with the oldest expected task. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rate_limited_priority_task_dispatcher_tb;
    import rlptd_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int CALLS_PER_PHASE = 85;
    localparam int NUM_ROWS        = 25;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_PRINTED     = 30;

    typedef struct packed {
        time_t            now_ms;
        logic             rf_present;
        logic             auto_mode;
        logic [SWR_W-1:0] swr_reading;
        logic             known;
        task_code_t       want;
    } call_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] now_ms, [47:32] swr_reading
    logic [S_TUSER_W-1:0]  s_tuser  = '0;   // [0] rf_present, [1] auto_mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [2:0] task_chosen, [7:3] zero
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the dispatcher state and settings
    time_t      stamp [NUM_TIMERS];
    bit         tune_armed;
    reg_val_t   period [NUM_TIMERS];
    reg_val_t   swr_limit;

    task_code_t expected_tasks [$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         steady_src  = 1'b0;
    bit         steady_sink = 1'b0;
    call_row_t  call_table [NUM_ROWS];

    rate_limited_priority_task_dispatcher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("%0t MISMATCH %s", $time, what);
    endtask

    function automatic bit cooled(input int t, input time_t now);
        time_t elapsed;
        elapsed = now - stamp[t];
        return elapsed >= time_t'(period[t]);
    endfunction

    function automatic task_code_t next_task(input time_t now, input bit rf,
                                             input bit auto_mode,
                                             input logic [SWR_W-1:0] swr);
        task_code_t pick;
        pick = TASK_NONE;
        if (cooled(T_POLL, now)) begin
            stamp[T_POLL] = now;
            pick = TASK_POLL;
        end else begin
            if (rf) begin
                if (cooled(T_FREQ, now)) begin
                    stamp[T_FREQ] = now;
                    pick = TASK_FREQ;
                end else if (cooled(T_MEAS, now)) begin
                    stamp[T_MEAS] = now;
                    pick = TASK_MEAS;
                end else if (cooled(T_TUNE, now)) begin
                    stamp[T_TUNE] = now;
                    if (auto_mode && tune_armed && swr > swr_limit) begin
                        tune_armed = 1'b0;
                        pick = TASK_TUNE_REQ;
                    end
                end
            end else begin
                tune_armed = 1'b1;
            end
            if (pick == TASK_NONE) begin
                if (cooled(T_BAR, now)) begin
                    stamp[T_BAR] = now;
                    pick = TASK_BAR;
                end else if (cooled(T_SAVE, now)) begin
                    stamp[T_SAVE] = now;
                    pick = TASK_SAVE;
                end
            end
        end
        return pick;
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic reg_val_t pick_setting();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 8) return reg_val_t'($urandom_range(1, 40));
        return reg_val_t'($urandom_range(41, 400));
    endfunction

    task automatic write_reg(input int idx, input logic [APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_TIMERS) period[idx] = val[REG_W-1:0];
        else if (idx == int'(REG_SWR_THRESH)) swr_limit = val[REG_W-1:0];
    endtask

    task automatic send_call(input call_row_t row);
        int         gap;
        task_code_t predicted;
        gap = pick_gap(steady_src);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.swr_reading, row.now_ms};
        s_tuser  <= {row.auto_mode, row.rf_present};
        do @(posedge aclk); while (!s_tready);
        predicted = next_task(row.now_ms, row.rf_present, row.auto_mode, row.swr_reading);
        expected_tasks.push_back(row.known ? row.want : predicted);
    endtask

    task automatic wait_idle();
        while (expected_tasks.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, checked against the oldest expected task
    always @(posedge aclk) begin : sink
        int         stall_left;
        task_code_t want;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(steady_sink) : 0;
            m_tready <= (stall_left == 0);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tasks.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected",
                                          m_tdata[TASK_W-1:0]));
            end else begin
                want = expected_tasks.pop_front();
                if (m_tdata[TASK_W-1:0] !== want)
                    report_mismatch($sformatf("task_chosen got %0d want %0d",
                                              m_tdata[TASK_W-1:0], want));
            end
        end
    end

    initial begin
        call_row_t             row;
        time_t                 tick;
        reg_val_t              setting;
        logic [APB_DATA_W-1:0] junk;
        int                    r;

        for (int t = 0; t < NUM_TIMERS; t++) stamp[t] = '0;
        tune_armed = 1'b1;
        period[T_POLL] = 16'd10;
        period[T_FREQ] = 16'd1000;
        period[T_MEAS] = 16'd20;
        period[T_TUNE] = 16'd200;
        period[T_BAR]  = 16'd33;
        period[T_SAVE] = 16'd200;
        swr_limit      = 16'd0;

        call_table = '{
            '{32'd0,    1'b0, 1'b0, 16'h0000, 1'b1, TASK_NONE},
            '{32'd10,   1'b0, 1'b0, 16'h0000, 1'b1, TASK_POLL},
            '{32'd15,   1'b1, 1'b0, 16'h0000, 1'b1, TASK_NONE},
            '{32'd20,   1'b1, 1'b0, 16'h0000, 1'b1, TASK_POLL},
            '{32'd25,   1'b1, 1'b0, 16'h0000, 1'b1, TASK_MEAS},
            '{32'd29,   1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_NONE},
            '{32'd35,   1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_POLL},
            '{32'd40,   1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_BAR},
            '{32'd44,   1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_NONE},
            '{32'd200,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_POLL},
            '{32'd205,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_MEAS},
            '{32'd206,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_TUNE_REQ},
            '{32'd207,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_BAR},
            '{32'd208,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_SAVE},
            '{32'd209,  1'b1, 1'b1, 16'hFFFF, 1'b1, TASK_NONE},
            // disarmed, then re-armed with RF gone
            '{32'd211,  1'b0, 1'b1, 16'hFFFF, 1'b0, TASK_NONE},
            '{32'd215,  1'b0, 1'b0, 16'h0000, 1'b0, TASK_NONE},
            '{32'd410,  1'b1, 1'b1, 16'h0001, 1'b0, TASK_NONE},
            '{32'd415,  1'b1, 1'b1, 16'h0001, 1'b0, TASK_NONE},
            // tune check in manual mode: stamps only
            '{32'd416,  1'b1, 1'b0, 16'h0001, 1'b0, TASK_NONE},
            '{32'd1300, 1'b1, 1'b1, 16'h0001, 1'b0, TASK_NONE},
            '{32'd1305, 1'b1, 1'b1, 16'h0001, 1'b0, TASK_NONE},
            // across the time wrap
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 16'h8000, 1'b0, TASK_NONE},
            '{32'h0000_0004, 1'b1, 1'b1, 16'h7FFF, 1'b0, TASK_NONE},
            '{32'h0000_0006, 1'b1, 1'b1, 16'h0000, 1'b0, TASK_NONE}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) send_call(call_table[i]);
        s_tvalid <= 1'b0;
        wait_idle();

        row  = '0;
        tick = 32'd2000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            steady_src  = ($urandom_range(0, 3) == 0);
            steady_sink = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < NUM_REGS; i++) begin
                if (p == 0) setting = '0;
                else if (p == 1) setting = '1;
                else if (i == int'(REG_SWR_THRESH)) setting = reg_val_t'($urandom);
                else setting = pick_setting();
                junk = $urandom;
                write_reg(i, {junk[APB_DATA_W-1:REG_W], setting});
            end
            if (p > 1) write_reg(NUM_REGS, $urandom);
            if ($urandom_range(0, 3) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, 200);

            for (int n = 0; n < CALLS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    row.now_ms      = $urandom;
                    row.rf_present  = 1'($urandom_range(0, 1));
                    row.auto_mode   = 1'($urandom_range(0, 1));
                    row.swr_reading = SWR_W'($urandom);
                end else begin
                    tick = tick + $urandom_range(0, 6);
                    row.now_ms = tick;
                    if ($urandom_range(0, 19) == 0) row.rf_present = ~row.rf_present;
                    if ($urandom_range(0, 19) == 0) row.auto_mode = ~row.auto_mode;
                    if ($urandom_range(0, 1) == 0)
                        row.swr_reading = SWR_W'(swr_limit + $urandom_range(0, 4) - 2);
                    else
                        row.swr_reading = SWR_W'($urandom);
                end
                row.known = 1'b0;
                row.want  = TASK_NONE;
                send_call(row);
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_tasks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
